@@ rtl/hio_pkg.sv @@
// shared widths and codes for the open-addressing hash insert block
package hio_pkg;

    localparam int KIND_W     = 2;
    localparam int KEY_W      = 32;
    localparam int SIDX_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 8;
    localparam int PC_W       = 9;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_READ     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd251;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;

endpackage

@@ rtl/hio_if.sv @@
// channel interfaces: request, result and configuration write
interface hio_in_if import hio_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [SIDX_W-1:0] slot_index;

    modport source (output valid, kind, key, slot_index, input ready);
    modport sink   (input valid, kind, key, slot_index, output ready);
endinterface

interface hio_out_if import hio_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    stored_key;
    logic                occupied;
    logic [PC_W-1:0]     probe_count;

    modport source (output valid, status, slot, stored_key, occupied, probe_count,
                    input ready);
    modport sink   (input valid, status, slot, stored_key, occupied, probe_count,
                    output ready);
endinterface

interface hio_cfg_if import hio_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/hio_ram.sv @@
// generic single-port-write, registered-read ram
module hio_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/hio_mod_unit.sv @@
// iterative restoring remainder unit, one dividend bit per cycle
module hio_mod_unit #(
    parameter int DVD_W = 32,
    parameter int DIV_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_rem
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W:0]   n_trial;
    logic [DIV_W:0]   n_diff;
    logic [DIV_W-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[DVD_W-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_rem   = (n_trial >= {1'b0, r_div}) ? n_diff[DIV_W-1:0] : n_trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/hash_insert_open_addressing_top.sv @@
// open-addressing hash table: insert with linear/quadratic probing, read, clear
//
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   kind, key, slot_index
//  o_out    out  valid/ready   status, slot, stored_key, occupied, probe_count
//  i_cfg    in   valid/ready   index, data (0 table_size, 1 probe_mode)
//
// insert first reduces key mod size in the bit-serial remainder unit,
// then does a ram read and a check per probe
// read reduces slot_index mod TABLE_DEPTH by a compare-subtract of the constant, then reads the ram
// clear and the pass after reset sweep the ram one slot a cycle, writing every slot empty
// a finished result sits in the output register; only the next result waits for ready
module hash_insert_open_addressing_top import hio_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    hio_in_if.sink    i_in,
    hio_out_if.source o_out,
    hio_cfg_if.sink   i_cfg
);

    localparam int KW     = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int DW_RAW = $clog2(TABLE_DEPTH + 1);
    localparam int DIV_W  = (DW_RAW > SIZE_W) ? DW_RAW : SIZE_W;
    localparam int MAXS   = (TABLE_DEPTH > 511) ? 511 : TABLE_DEPTH;
    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAXS);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_MOD_WAIT,
        S_PROBE_ADDR,
        S_PROBE_CHECK,
        S_READ_ADDR,
        S_READ_DATA,
        S_FINISH
    } t_state;

    function automatic logic [SIZE_W-1:0] add_mod(
        input logic [SIZE_W-1:0] a,
        input logic [SIZE_W-1:0] b,
        input logic [SIZE_W-1:0] s
    );
        logic [SIZE_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, s}) begin
            t = t - {1'b0, s};
        end
        return t[SIZE_W-1:0];
    endfunction

    // slot_index mod TABLE_DEPTH by compare and subtract of the shifted depth
    function automatic logic [AW-1:0] read_addr(input logic [SIDX_W-1:0] s);
        logic [SIDX_W-1:0] r;
        r = s;
        for (int k = SIDX_W - 1; k >= 0; k--) begin
            if ((longint'(TABLE_DEPTH) << k) < (longint'(1) << SIDX_W)) begin
                if (r >= SIDX_W'(TABLE_DEPTH << k)) begin
                    r = r - SIDX_W'(TABLE_DEPTH << k);
                end
            end
        end
        return AW'(r);
    endfunction

    t_state              r_state;
    logic [KW-1:0]       r_key;
    logic [SIZE_W-1:0]   r_size;
    logic                r_quad;
    logic [SIZE_W-1:0]   r_base;
    logic [SIZE_W-1:0]   r_off;
    logic [SIZE_W-1:0]   r_d;
    logic [SIZE_W-1:0]   r_i;
    logic [SIZE_W-1:0]   r_idx;
    logic [AW-1:0]       r_raddr;
    logic [AW-1:0]       r_sweep;
    logic                r_sweep_res;
    logic [SIZE_W-1:0]   r_table_size;
    logic                r_probe_mode;

    logic [STATUS_W-1:0] r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [KEY_W-1:0]    r_res_key;
    logic                r_res_occ;
    logic [PC_W-1:0]     r_res_pc;

    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [SLOT_W-1:0]   r_o_slot;
    logic [KEY_W-1:0]    r_o_key;
    logic                r_o_occ;
    logic [PC_W-1:0]     r_o_pc;

    logic                n_accept;
    logic [SIZE_W-1:0]   n_size;
    logic [SIZE_W-1:0]   n_idx;
    logic                mod_start;
    logic [KEY_W-1:0]    mod_dividend;
    logic [DIV_W-1:0]    mod_divisor;
    logic                mod_done;
    logic [DIV_W-1:0]    mod_rem;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KW:0]         ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [KW:0]         ram_rdata;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign n_accept    = i_in.valid && (r_state == S_IDLE);

    // effective size, clamped to SIZE_MIN below and to the ram depth (at most 511) above
    always_comb begin
        if (r_table_size < SIZE_MIN) begin
            n_size = SIZE_MIN;
        end else if (r_table_size > MAX_SIZE) begin
            n_size = MAX_SIZE;
        end else begin
            n_size = r_table_size;
        end
    end

    assign n_idx = add_mod(r_base, r_off, r_size);

    always_comb begin
        mod_start    = n_accept && (i_in.kind == KIND_INSERT);
        mod_dividend = KEY_W'(i_in.key[KW-1:0]);
        mod_divisor  = DIV_W'(n_size);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sweep;
        ram_wdata = '0;
        ram_raddr = r_raddr;
        case (r_state)
            S_SWEEP: begin
                ram_we = 1'b1;
            end
            S_PROBE_ADDR: begin
                ram_raddr = AW'(n_idx);
            end
            S_PROBE_CHECK: begin
                ram_we    = !ram_rdata[KW];
                ram_waddr = AW'(r_idx);
                ram_wdata = {1'b1, r_key};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    hio_mod_unit #(
        .DVD_W (KEY_W),
        .DIV_W (DIV_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // each word holds the valid bit above the key
    hio_ram #(
        .WIDTH (KW + 1),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep      <= '0;
            r_sweep_res  <= 1'b0;
            r_table_size <= SIZE_RESET;
            r_probe_mode <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_TABLE_SIZE) begin
                    r_table_size <= i_cfg.data;
                end else if (i_cfg.index == CFG_PROBE_MODE) begin
                    r_probe_mode <= i_cfg.data[0];
                end
            end

            if (o_out.ready && (r_state != S_FINISH)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == LAST_ADDR) begin
                        r_sweep <= '0;
                        r_state <= r_sweep_res ? S_FINISH : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_key        <= i_in.key[KW-1:0];
                        r_size       <= n_size;
                        r_quad       <= r_probe_mode;
                        r_res_status <= ST_CLEARED;
                        r_res_slot   <= '0;
                        r_res_key    <= '0;
                        r_res_occ    <= 1'b0;
                        r_res_pc     <= '0;
                        case (i_in.kind)
                            KIND_INSERT: r_state <= S_MOD_WAIT;
                            KIND_READ: begin
                                r_raddr <= read_addr(i_in.slot_index);
                                r_state <= S_READ_ADDR;
                            end
                            KIND_CLEAR: begin
                                r_sweep_res <= 1'b1;
                                r_state     <= S_SWEEP;
                            end
                            default:     r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MOD_WAIT: begin
                    if (mod_done) begin
                        r_base  <= SIZE_W'(mod_rem);
                        r_off   <= '0;
                        r_d     <= SIZE_W'(1);
                        r_i     <= '0;
                        r_state <= S_PROBE_ADDR;
                    end
                end
                S_PROBE_ADDR: begin
                    r_idx <= n_idx;
                    // step the offset: i for linear, i*i mod size for quadratic
                    if (r_quad) begin
                        r_off <= add_mod(r_off, r_d, r_size);
                        r_d   <= add_mod(r_d, SIZE_W'(2), r_size);
                    end else begin
                        r_off <= add_mod(r_off, SIZE_W'(1), r_size);
                    end
                    r_state <= S_PROBE_CHECK;
                end
                S_PROBE_CHECK: begin
                    if (!ram_rdata[KW]) begin
                        r_res_status <= ST_INSERTED;
                        r_res_slot   <= SLOT_W'(r_idx);
                        r_res_key    <= KEY_W'(r_key);
                        r_res_occ    <= 1'b1;
                        r_res_pc     <= PC_W'(r_i);
                        r_state      <= S_FINISH;
                    end else if (r_i == r_size - 1'b1) begin
                        r_res_status <= ST_FULL;
                        r_res_pc     <= PC_W'(r_size);
                        r_state      <= S_FINISH;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_PROBE_ADDR;
                    end
                end
                S_READ_ADDR: begin
                    r_state <= S_READ_DATA;
                end
                S_READ_DATA: begin
                    r_res_status <= ST_READ;
                    r_res_slot   <= SLOT_W'(r_raddr);
                    r_res_occ    <= ram_rdata[KW];
                    r_res_key    <= ram_rdata[KW] ? KEY_W'(ram_rdata[KW-1:0]) : '0;
                    r_state      <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid   <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_slot    <= r_res_slot;
                        r_o_key     <= r_res_key;
                        r_o_occ     <= r_res_occ;
                        r_o_pc      <= r_res_pc;
                        r_sweep_res <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.status      = r_o_status;
    assign o_out.slot        = r_o_slot;
    assign o_out.stored_key  = r_o_key;
    assign o_out.occupied    = r_o_occ;
    assign o_out.probe_count = r_o_pc;

endmodule
